// ===== rtl/core/ctrr_pkg.sv =====
// ============================================================================
// ctrr_pkg: shared types and constants for the contextual tag rewrite rule
// Holds the template codes, register indexes, window geometry and the small
// structs that travel between the front queue and the rule engine.
// ============================================================================
package ctrr_pkg;

   // Default tag width and queue depth handed to the top level.
   localparam int TAG_BITS_DEFAULT    = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Window geometry: three words of context on each side of the released word.
   localparam int LOOK = 3;
   localparam int WIN  = 7;

   // Register file.
   localparam int CSR_INDEX_BITS = 3;
   localparam int TEMPLATE_BITS  = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMPLATE_SEL = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FROM_TAG     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TO_TAG       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_CUE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_CUE   = 3'd4;

   // Context templates.
   typedef enum logic [TEMPLATE_BITS-1:0] {
      TPL_PREV            = 4'd0,
      TPL_NEXT            = 4'd1,
      TPL_TWO_BEFORE      = 4'd2,
      TPL_TWO_AFTER       = 4'd3,
      TPL_ONE_OF_2_BEFORE = 4'd4,
      TPL_ONE_OF_2_AFTER  = 4'd5,
      TPL_ONE_OF_3_BEFORE = 4'd6,
      TPL_ONE_OF_3_AFTER  = 4'd7,
      TPL_PREV_NEXT       = 4'd8,
      TPL_PREV_TWO_BEFORE = 4'd9,
      TPL_NEXT_TWO_AFTER  = 4'd10
   } template_type;

   // Kind of a queued word: an ordinary word or the end of a sentence.
   typedef enum logic {
      KIND_WORD = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   // Rule engine states.
   typedef enum logic {
      ST_RUN   = 1'b0,
      ST_FLUSH = 1'b1
   } state_type;

   // Number of sentence words available before and after the released word.
   typedef struct packed {
      logic [1:0] prior;
      logic [1:0] after;
   } ctx_type;

   // Status of the rule engine, watched at the top level.
   typedef struct packed {
      logic       flushing;
      logic [1:0] pending;
   } back_stat_type;

endpackage

// ===== rtl/core/ctrr_front.sv =====
// ============================================================================
// ctrr_front: input queue of the contextual tag rewrite rule
// Accepts request transactions, classifies each word as an ordinary word or
// a sentence end and holds it in a short queue until the rule engine takes it.
// ============================================================================
module ctrr_front #(
   parameter int TAG_BITS    = ctrr_pkg::TAG_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ctrr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [TAG_BITS-1:0]     req_tag_in,
   input  logic                    req_sentence_last_in,
   output logic                    q_valid,
   output logic [TAG_BITS-1:0]     q_tag,
   output ctrr_pkg::kind_type      q_kind,
   input  logic                    q_pop
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   logic [TAG_BITS-1:0]  tag_mem [QUEUE_DEPTH];
   ctrr_pkg::kind_type   kind_mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 push;
   ctrr_pkg::kind_type   kind;

   // Classify the incoming word.
   assign kind = req_sentence_last_in ? ctrr_pkg::KIND_END : ctrr_pkg::KIND_WORD;

   // Handshake and head of queue.
   assign req_ready = (count_ff != FULL_CNT);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_tag     = tag_mem[head_ff];
   assign q_kind    = kind_mem[head_ff];

   // Pointer and fill count updates.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_BITS'(1);
      end
      if (q_pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_BITS'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         tag_mem[tail_ff]  <= req_tag_in;
         kind_mem[tail_ff] <= kind;
      end
   end

endmodule

// ===== rtl/core/ctrr_match.sv =====
// ============================================================================
// ctrr_match: context template compare
// Decides whether the rule fires on the word in the middle of the window,
// given the selected template and how much of the sentence lies on each side.
// ============================================================================
module ctrr_match #(
   parameter int TAG_BITS = ctrr_pkg::TAG_BITS_DEFAULT
) (
   input  logic [TAG_BITS-1:0]                win [ctrr_pkg::WIN],
   input  ctrr_pkg::ctx_type                  ctx,
   input  logic [ctrr_pkg::TEMPLATE_BITS-1:0] template_sel,
   input  logic [TAG_BITS-1:0]                from_tag,
   input  logic [TAG_BITS-1:0]                first_cue,
   input  logic [TAG_BITS-1:0]                second_cue,
   output logic                               fire
);

   logic [ctrr_pkg::WIN-1:0] eq1;
   logic [ctrr_pkg::WIN-1:0] eq2;
   logic                     ctx_ok;

   // Compare every window slot against both cue tags.
   always_comb begin
      for (int i = 0; i < ctrr_pkg::WIN; i++) begin
         eq1[i] = (win[i] == first_cue);
         eq2[i] = (win[i] == second_cue);
      end
   end

   // Template selection; the context must lie wholly inside the sentence.
   always_comb begin
      case (template_sel)
         ctrr_pkg::TPL_PREV:
            ctx_ok = (ctx.prior >= 2'd1) && eq1[2];
         ctrr_pkg::TPL_NEXT:
            ctx_ok = (ctx.after >= 2'd1) && eq1[4];
         ctrr_pkg::TPL_TWO_BEFORE:
            ctx_ok = (ctx.prior >= 2'd2) && eq1[1];
         ctrr_pkg::TPL_TWO_AFTER:
            ctx_ok = (ctx.after >= 2'd2) && eq1[5];
         ctrr_pkg::TPL_ONE_OF_2_BEFORE:
            ctx_ok = (ctx.prior >= 2'd2) && (eq1[2] || eq1[1]);
         ctrr_pkg::TPL_ONE_OF_2_AFTER:
            ctx_ok = (ctx.after >= 2'd2) && (eq1[4] || eq1[5]);
         ctrr_pkg::TPL_ONE_OF_3_BEFORE:
            ctx_ok = (ctx.prior == 2'd3) && (eq1[2] || eq1[1] || eq1[0]);
         ctrr_pkg::TPL_ONE_OF_3_AFTER:
            ctx_ok = (ctx.after == 2'd3) && (eq1[4] || eq1[5] || eq1[6]);
         ctrr_pkg::TPL_PREV_NEXT:
            ctx_ok = (ctx.prior >= 2'd1) && (ctx.after >= 2'd1) && eq1[2] && eq2[4];
         ctrr_pkg::TPL_PREV_TWO_BEFORE:
            ctx_ok = (ctx.prior >= 2'd2) && eq1[2] && eq2[1];
         ctrr_pkg::TPL_NEXT_TWO_AFTER:
            ctx_ok = (ctx.after >= 2'd2) && eq1[4] && eq2[5];
         default:
            ctx_ok = 1'b0;
      endcase
   end

   assign fire = (win[ctrr_pkg::LOOK] == from_tag) && ctx_ok;

endmodule

// ===== rtl/core/ctrr_back.sv =====
// ============================================================================
// ctrr_back: rule engine of the contextual tag rewrite rule
// Keeps the seven-word window of original tags, takes words from the queue,
// releases one word per cycle into the response register while it is free
// or being emptied, and drains the held words at each sentence end.
// ============================================================================
module ctrr_back #(
   parameter int TAG_BITS = ctrr_pkg::TAG_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  logic [TAG_BITS-1:0]                q_tag,
   input  ctrr_pkg::kind_type                 q_kind,
   output logic                               q_pop,
   input  logic [ctrr_pkg::TEMPLATE_BITS-1:0] template_sel,
   input  logic [TAG_BITS-1:0]                from_tag,
   input  logic [TAG_BITS-1:0]                to_tag,
   input  logic [TAG_BITS-1:0]                first_cue,
   input  logic [TAG_BITS-1:0]                second_cue,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [TAG_BITS-1:0]                rsp_tag_out,
   output logic                               rsp_rewritten,
   output logic                               rsp_sentence_last_out,
   output ctrr_pkg::back_stat_type            stat
);

   localparam int WIN  = ctrr_pkg::WIN;
   localparam int LOOK = ctrr_pkg::LOOK;

   ctrr_pkg::state_type  state_ff, state_in;
   logic [TAG_BITS-1:0]  win_ff [WIN];
   logic [TAG_BITS-1:0]  win_in [WIN];
   logic [TAG_BITS-1:0]  win_ins [WIN];
   logic [TAG_BITS-1:0]  cur_win [WIN];
   logic [1:0]           pending_ff, pending_in;
   logic [1:0]           earlier_ff, earlier_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                 rsp_rewritten_ff, rsp_rewritten_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;
   logic                 pop;
   logic                 release_word;
   logic                 use_ins;
   logic                 rel_last;
   logic [1:0]           rel_after;
   ctrr_pkg::ctx_type    ctx;
   logic                 fire;

   // The response register can take a word when empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Window with the queue head written behind the held words.
   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         win_ins[i] = win_ff[i];
      end
      for (int i = LOOK; i < WIN; i++) begin
         if (pending_ff == 2'(i - LOOK)) begin
            win_ins[i] = q_tag;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctrr_pkg::ST_RUN: begin
            if (q_valid && (q_kind == ctrr_pkg::KIND_END) && out_free &&
                (pending_ff != 2'd0)) begin
               state_in = ctrr_pkg::ST_FLUSH;
            end
         end
         ctrr_pkg::ST_FLUSH: begin
            if (out_free && (pending_ff == 2'd1)) begin
               state_in = ctrr_pkg::ST_RUN;
            end
         end
         default: state_in = ctrr_pkg::ST_RUN;
      endcase
   end

   // Control outputs: which word is taken and which word is released.
   always_comb begin
      pop          = 1'b0;
      release_word = 1'b0;
      use_ins      = 1'b0;
      rel_after    = 2'd0;
      rel_last     = 1'b0;
      case (state_ff)
         ctrr_pkg::ST_RUN: begin
            use_ins = 1'b1;
            if (q_valid) begin
               if (q_kind == ctrr_pkg::KIND_END) begin
                  // Sentence end: release the oldest held word right away.
                  if (out_free) begin
                     pop          = 1'b1;
                     release_word = 1'b1;
                     rel_after    = pending_ff;
                     rel_last     = (pending_ff == 2'd0);
                  end
               end else if (pending_ff == 2'd3) begin
                  // Full lookahead: one word in, one word out.
                  if (out_free) begin
                     pop          = 1'b1;
                     release_word = 1'b1;
                     rel_after    = 2'd3;
                  end
               end else begin
                  pop = 1'b1;
               end
            end
         end
         ctrr_pkg::ST_FLUSH: begin
            if (out_free) begin
               release_word = 1'b1;
               rel_after    = pending_ff - 2'd1;
               rel_last     = (pending_ff == 2'd1);
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Window that the released word is judged against.
   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         cur_win[i] = use_ins ? win_ins[i] : win_ff[i];
      end
   end

   assign ctx.prior = earlier_ff;
   assign ctx.after = rel_after;

   ctrr_match #(
      .TAG_BITS (TAG_BITS)
   ) u_match (
      .win          (cur_win),
      .ctx          (ctx),
      .template_sel (template_sel),
      .from_tag     (from_tag),
      .first_cue    (first_cue),
      .second_cue   (second_cue),
      .fire         (fire)
   );

   // Window, counters and response register next values.
   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         win_in[i] = win_ff[i];
      end
      if (release_word) begin
         for (int i = 0; i < WIN - 1; i++) begin
            win_in[i] = cur_win[i + 1];
         end
         win_in[WIN - 1] = cur_win[WIN - 1];
      end else if (pop) begin
         for (int i = 0; i < WIN; i++) begin
            win_in[i] = win_ins[i];
         end
      end

      pending_in = pending_ff;
      if (pop && (q_kind == ctrr_pkg::KIND_WORD) && (pending_ff != 2'd3)) begin
         pending_in = pending_ff + 2'd1;
      end else if ((state_ff == ctrr_pkg::ST_FLUSH) && release_word) begin
         pending_in = pending_ff - 2'd1;
      end

      earlier_in = earlier_ff;
      if (release_word) begin
         if (rel_last) begin
            earlier_in = 2'd0;
         end else if (earlier_ff != 2'd3) begin
            earlier_in = earlier_ff + 2'd1;
         end
      end

      rsp_valid_in     = rsp_valid_ff;
      rsp_tag_in       = rsp_tag_ff;
      rsp_rewritten_in = rsp_rewritten_ff;
      rsp_last_in      = rsp_last_ff;
      if (release_word) begin
         rsp_valid_in     = 1'b1;
         rsp_tag_in       = fire ? to_tag : cur_win[LOOK];
         rsp_rewritten_in = fire;
         rsp_last_in      = rel_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctrr_pkg::ST_RUN;
         pending_ff   <= 2'd0;
         earlier_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         earlier_ff   <= earlier_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN; i++) begin
         win_ff[i] <= win_in[i];
      end
      rsp_tag_ff       <= rsp_tag_in;
      rsp_rewritten_ff <= rsp_rewritten_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign q_pop                 = pop;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_tag_out           = rsp_tag_ff;
   assign rsp_rewritten         = rsp_rewritten_ff;
   assign rsp_sentence_last_out = rsp_last_ff;
   assign stat.flushing         = (state_ff == ctrr_pkg::ST_FLUSH);
   assign stat.pending          = pending_ff;

endmodule

// ===== rtl/core/contextual_tag_rewrite_rule.sv =====
// ============================================================================
// contextual_tag_rewrite_rule: one contextual part-of-speech rewrite rule
// Rewrites from_tag to to_tag where the selected context template matches
// the original tags of the same sentence; output trails input by three words.
// ============================================================================
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_tag_in, req_sentence_last_in
//   rsp      out        rsp_valid / rsp_ready  rsp_tag_out, rsp_rewritten,
//                                              rsp_sentence_last_out
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One word per cycle is accepted in steady state while the response is not stalled;
// the word that an accepted word releases is registered in the response register.
// A sentence end with n held words releases n + 1 words, one per cycle while the
// response is free, and the engine takes no word during the last n of them; the
// input queue keeps accepting until its QUEUE_DEPTH entries are full.
// Reset is synchronous and clears the queue, counters and rule registers;
// there is no clearing pass.
// A stalled response stops the engine only when it has a word to release.
// Register writes are always ready.
//
module contextual_tag_rewrite_rule #(
   parameter int TAG_BITS    = ctrr_pkg::TAG_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ctrr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [TAG_BITS-1:0]                 req_tag_in,
   input  logic                                req_sentence_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [TAG_BITS-1:0]                 rsp_tag_out,
   output logic                                rsp_rewritten,
   output logic                                rsp_sentence_last_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ctrr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TAG_BITS-1:0]                 csr_data
);

   logic [ctrr_pkg::TEMPLATE_BITS-1:0] template_sel_ff;
   logic [TAG_BITS-1:0]                from_tag_ff;
   logic [TAG_BITS-1:0]                to_tag_ff;
   logic [TAG_BITS-1:0]                first_cue_ff;
   logic [TAG_BITS-1:0]                second_cue_ff;
   logic                               q_valid;
   logic [TAG_BITS-1:0]                q_tag;
   ctrr_pkg::kind_type                 q_kind;
   logic                               q_pop;
   ctrr_pkg::back_stat_type            stat;

   // Rule registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         template_sel_ff <= '0;
         from_tag_ff     <= '0;
         to_tag_ff       <= '0;
         first_cue_ff    <= '0;
         second_cue_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ctrr_pkg::CSR_TEMPLATE_SEL:
               template_sel_ff <= csr_data[ctrr_pkg::TEMPLATE_BITS-1:0];
            ctrr_pkg::CSR_FROM_TAG:   from_tag_ff   <= csr_data;
            ctrr_pkg::CSR_TO_TAG:     to_tag_ff     <= csr_data;
            ctrr_pkg::CSR_FIRST_CUE:  first_cue_ff  <= csr_data;
            ctrr_pkg::CSR_SECOND_CUE: second_cue_ff <= csr_data;
            default:                  second_cue_ff <= second_cue_ff;
         endcase
      end
   end

   // Input queue.
   ctrr_front #(
      .TAG_BITS    (TAG_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_tag_in           (req_tag_in),
      .req_sentence_last_in (req_sentence_last_in),
      .q_valid              (q_valid),
      .q_tag                (q_tag),
      .q_kind               (q_kind),
      .q_pop                (q_pop)
   );

   // Rule engine.
   ctrr_back #(
      .TAG_BITS (TAG_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_tag                 (q_tag),
      .q_kind                (q_kind),
      .q_pop                 (q_pop),
      .template_sel          (template_sel_ff),
      .from_tag              (from_tag_ff),
      .to_tag                (to_tag_ff),
      .first_cue             (first_cue_ff),
      .second_cue            (second_cue_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_tag_out           (rsp_tag_out),
      .rsp_rewritten         (rsp_rewritten),
      .rsp_sentence_last_out (rsp_sentence_last_out),
      .stat                  (stat)
   );

   // A drain always has at least one held word left to release.
   assert property (@(posedge clock) disable iff (reset)
      stat.flushing |-> (stat.pending != 2'd0))
      else $error("rule engine draining with no held words");

   // A drain starts only together with a released word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(stat.flushing) |-> rsp_valid)
      else $error("drain started without a released word");

   // A full queue always presents a word to the rule engine.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("input queue full but head not valid");

endmodule
